### hw/rtl/selective_repeat_receiver_assert.svh
// ----------------------------------------------------------------------------
// Selective repeat receiver assertion macros
// Concurrent checks on aclk, held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property at every clock edge outside reset.
`define SRR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that the antecedent implies the consequent in the same cycle.
`define SRR_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that the antecedent implies the consequent in the next cycle.
`define SRR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SRR_ASSERT(name, prop, msg)
`define SRR_ASSERT_IMPL(name, ante, cons, msg)
`define SRR_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

### hw/rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// Selective repeat receiver package
// Sequence space, slot geometry, result codes and the slot memory request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srr_pkg;

    localparam int SEQ_SPACE   = 7;
    localparam int RECV_WINDOW = 6;
    localparam int IDX_W       = $clog2(SEQ_SPACE);

    // Deliveries per request are capped by the window and the sequence space
    localparam int DELIV_MAX   = (RECV_WINDOW < SEQ_SPACE) ? RECV_WINDOW : SEQ_SPACE;
    localparam int DCNT_W      = $clog2(DELIV_MAX + 1);

    localparam int LO_W        = 64;
    localparam int MID_W       = 64;
    localparam int HI_W        = 32;
    localparam int SLOT_W      = LO_W + MID_W + HI_W;

    localparam int ACKNUM_W    = 3;
    localparam int ACKSUM_W    = 10;
    // Ack payload is twenty ASCII '0' bytes
    localparam int ACK_FILL_SUM = 20 * 48;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef logic [IDX_W-1:0]  slot_idx_t;
    typedef logic [SLOT_W-1:0] slot_data_t;

    typedef struct packed {
        logic      wr_en;
        slot_idx_t wr_addr;
        logic      rd_en;
        slot_idx_t rd_addr;
    } slot_req_t;

endpackage

`default_nettype wire

### hw/rtl/srr_slot_ram.sv
// ----------------------------------------------------------------------------
// Slot payload memory
// One write and one registered read per cycle, one slot per sequence number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srr_slot_ram (
    input  wire logic               aclk,
    input  wire srr_pkg::slot_req_t req,
    input  wire srr_pkg::slot_data_t wr_data,
    output      srr_pkg::slot_data_t rd_data
);
    import srr_pkg::*;

    slot_data_t mem [SEQ_SPACE];
    slot_data_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/selective_repeat_receiver.sv
// ----------------------------------------------------------------------------
// Selective repeat receiver
// Checks arriving packets, buffers in-window payloads and releases them in
// order, followed by an ack.
// ----------------------------------------------------------------------------
// One request is taken at a time. On acceptance the request is captured and
// its byte sums are formed; then come the checksum compare and window test
// (the payload is written to its slot here), then one slot read per
// delivered payload: each delivery is a slot memory read followed by a load
// of the result register. An in-window request then finds the in-order run
// over, and a closing ack ends it. A corrupted or old request gets only the
// ack, an ignored one no result at all. The result side can stall each load.
// Results leave through a single output register; a new request is accepted
// while the last result of the previous one still waits there. Payloads live
// in a synchronous slot memory with no reset; only the sequencer state, the
// per-slot full bits, the window base, the ack toggle and ack bit, the
// delivery count, the ack number and the output valid reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_receiver (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire logic signed [31:0]            s_seq_num,
    input  wire logic signed [31:0]            s_ack_field,
    input  wire logic signed [31:0]            s_pkt_checksum,
    input  wire logic [srr_pkg::LO_W-1:0]      s_payload_lo,
    input  wire logic [srr_pkg::MID_W-1:0]     s_payload_mid,
    input  wire logic [srr_pkg::HI_W-1:0]      s_payload_hi,

    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output      logic                          m_kind,
    output      logic                          m_ack_seq,
    output      logic [srr_pkg::ACKNUM_W-1:0]  m_ack_number,
    output      logic [srr_pkg::ACKSUM_W-1:0]  m_ack_sum,
    output      logic [srr_pkg::LO_W-1:0]      m_data_lo,
    output      logic [srr_pkg::MID_W-1:0]     m_data_mid,
    output      logic [srr_pkg::HI_W-1:0]      m_data_hi,
    output      logic                          m_last
);
    import srr_pkg::*;

    `include "selective_repeat_receiver_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_SEND_DATA,
        ST_SEND_ACK
    } state_t;

    // Partial byte sums: 8 signed bytes fit 11 bits, the total fits 13
    localparam int PSUM_W = 11;
    localparam int BSUM_W = 13;

    function automatic logic signed [PSUM_W-1:0] byte_sum8(input logic [63:0] word);
        logic signed [PSUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            acc = acc + PSUM_W'($signed(word[8*i +: 8]));
        end
        return acc;
    endfunction

    function automatic logic signed [PSUM_W-1:0] byte_sum4(input logic [31:0] word);
        logic signed [PSUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < 4; i++) begin
            acc = acc + PSUM_W'($signed(word[8*i +: 8]));
        end
        return acc;
    endfunction

    function automatic slot_idx_t idx_inc(input slot_idx_t idx);
        return (idx == slot_idx_t'(SEQ_SPACE - 1)) ? '0 : idx + slot_idx_t'(1);
    endfunction

    function automatic slot_idx_t idx_dec(input slot_idx_t idx);
        return (idx == '0) ? slot_idx_t'(SEQ_SPACE - 1) : idx - slot_idx_t'(1);
    endfunction

    state_t                   state_reg;
    logic                     ack_toggle_reg;
    logic                     ack_bit_reg;
    slot_idx_t                base_reg;
    logic [SEQ_SPACE-1:0]     full_reg;
    logic [DCNT_W-1:0]        dcnt_reg;
    slot_idx_t                ack_num_reg;

    // Request capture
    logic [31:0]              seq_reg;
    logic [31:0]              sa_reg;
    logic [31:0]              cks_reg;
    logic signed [PSUM_W-1:0] ps_lo_reg;
    logic signed [PSUM_W-1:0] ps_mid_reg;
    logic signed [PSUM_W-1:0] ps_hi_reg;
    slot_data_t               payload_reg;

    // Result register
    logic                     m_valid_reg;
    logic                     m_kind_reg;
    logic                     m_ack_seq_reg;
    logic [ACKNUM_W-1:0]      m_ack_number_reg;
    logic [ACKSUM_W-1:0]      m_ack_sum_reg;
    slot_data_t               m_data_reg;
    logic                     m_last_reg;

    // Check stage
    logic signed [BSUM_W-1:0] bsum;
    logic [31:0]              sum_full;
    logic                     pkt_good;
    logic                     seq_in_range;
    slot_idx_t                seq_idx;
    logic [IDX_W:0]           base_offset;
    logic                     seq_in_win;
    logic                     is_old;
    logic                     can_deliver;
    logic                     out_free;
    logic                     load_result;
    logic                     accept;

    slot_req_t                slot_req;
    slot_data_t               slot_rd_data;

    assign accept       = s_valid && s_ready;
    assign s_ready      = (state_reg == ST_IDLE);
    assign out_free     = !m_valid_reg || m_ready;
    assign load_result  = ((state_reg == ST_SEND_DATA) || (state_reg == ST_SEND_ACK))
                          && out_free;

    assign bsum         = BSUM_W'(ps_lo_reg) + BSUM_W'(ps_mid_reg) + BSUM_W'(ps_hi_reg);
    assign sum_full     = sa_reg + 32'(bsum);
    assign pkt_good     = (sum_full == cks_reg);
    assign seq_in_range = (seq_reg < 32'(SEQ_SPACE));
    assign seq_idx      = seq_reg[IDX_W-1:0];

    // Distance from the window base, modulo the sequence space
    assign base_offset = (seq_idx >= base_reg)
                       ? ({1'b0, seq_idx} - {1'b0, base_reg})
                       : ({1'b0, seq_idx} + (IDX_W+1)'(SEQ_SPACE) - {1'b0, base_reg});
    assign seq_in_win = (base_offset < (IDX_W+1)'(RECV_WINDOW));
    assign is_old     = (base_offset >= (IDX_W+1)'(SEQ_SPACE - RECV_WINDOW));

    assign can_deliver = (dcnt_reg < DCNT_W'(DELIV_MAX)) && full_reg[base_reg];

    // Store a new in-window payload; read the base slot while releasing
    always_comb begin
        slot_req.wr_en   = (state_reg == ST_CHECK) && pkt_good && seq_in_range
                           && seq_in_win && !full_reg[seq_idx];
        slot_req.wr_addr = seq_idx;
        slot_req.rd_en   = (state_reg == ST_READ) && can_deliver;
        slot_req.rd_addr = base_reg;
    end

    srr_slot_ram u_slot_ram (
        .aclk    (aclk),
        .req     (slot_req),
        .wr_data (payload_reg),
        .rd_data (slot_rd_data)
    );

    // Capture the request and form byte sums on acceptance
    always_ff @(posedge aclk) begin
        if (accept) begin
            seq_reg     <= s_seq_num;
            sa_reg      <= s_seq_num + s_ack_field;
            cks_reg     <= s_pkt_checksum;
            ps_lo_reg   <= byte_sum8(s_payload_lo);
            ps_mid_reg  <= byte_sum8(s_payload_mid);
            ps_hi_reg   <= byte_sum4(s_payload_hi);
            payload_reg <= {s_payload_hi, s_payload_mid, s_payload_lo};
        end
    end

    // Sequencer, window state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ack_toggle_reg <= 1'b1;
            ack_bit_reg    <= 1'b0;
            base_reg       <= '0;
            full_reg       <= '0;
            dcnt_reg       <= '0;
            ack_num_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // Raise valid on a load; drop it once the result is taken
            if (load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        // Flip the ack toggle on every request, ignored ones too
                        ack_bit_reg    <= ack_toggle_reg;
                        ack_toggle_reg <= !ack_toggle_reg;
                        state_reg      <= ST_CHECK;
                    end
                end

                ST_CHECK: begin
                    dcnt_reg <= '0;
                    if (!pkt_good) begin
                        // Corrupted: ack the slot just before the window
                        ack_num_reg <= idx_dec(base_reg);
                        state_reg   <= ST_SEND_ACK;
                    end else if (!seq_in_range) begin
                        state_reg <= ST_IDLE;
                    end else if (seq_in_win) begin
                        full_reg[seq_idx] <= 1'b1;
                        ack_num_reg       <= seq_idx;
                        state_reg         <= ST_READ;
                    end else if (is_old) begin
                        ack_num_reg <= seq_idx;
                        state_reg   <= ST_SEND_ACK;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_READ: begin
                    if (can_deliver) begin
                        // Release the base slot and slide the window
                        full_reg[base_reg] <= 1'b0;
                        base_reg           <= idx_inc(base_reg);
                        dcnt_reg           <= dcnt_reg + DCNT_W'(1);
                        state_reg          <= ST_SEND_DATA;
                    end else begin
                        state_reg <= ST_SEND_ACK;
                    end
                end

                ST_SEND_DATA: begin
                    if (out_free) begin
                        m_kind_reg       <= KIND_DELIVER;
                        m_ack_seq_reg    <= 1'b0;
                        m_ack_number_reg <= '0;
                        m_ack_sum_reg    <= '0;
                        m_data_reg       <= slot_rd_data;
                        m_last_reg       <= 1'b0;
                        state_reg        <= ST_READ;
                    end
                end

                ST_SEND_ACK: begin
                    if (out_free) begin
                        m_kind_reg       <= KIND_ACK;
                        m_ack_seq_reg    <= ack_bit_reg;
                        m_ack_number_reg <= ACKNUM_W'(ack_num_reg);
                        m_ack_sum_reg    <= ACKSUM_W'(32'(ack_bit_reg) + 32'(ack_num_reg)
                                                      + 32'(ACK_FILL_SUM));
                        m_data_reg       <= '0;
                        m_last_reg       <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_ack_seq    = m_ack_seq_reg;
    assign m_ack_number = m_ack_number_reg;
    assign m_ack_sum    = m_ack_sum_reg;
    assign m_data_lo    = m_data_reg[LO_W-1:0];
    assign m_data_mid   = m_data_reg[LO_W +: MID_W];
    assign m_data_hi    = m_data_reg[LO_W+MID_W +: HI_W];
    assign m_last       = m_last_reg;

    // Accepted request always goes to the checksum compare next
    `SRR_ASSERT_NEXT(a_accept_to_check, accept, state_reg == ST_CHECK, "accept not followed by check")
    // Block is not ready in the cycle after taking a request
    `SRR_ASSERT_NEXT(a_busy_after_accept, accept, !s_ready, "ready right after accept")
    // Held payloads never exceed the receive window
    `SRR_ASSERT(a_full_bound, $countones(full_reg) <= RECV_WINDOW, "too many full slots")
    // Only an ack closes a request; deliveries never carry last
    `SRR_ASSERT_IMPL(a_last_is_ack, m_valid_reg, m_last_reg == m_kind_reg, "last and kind disagree")

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Selective repeat receiver testbench
// Drives checked, corrupted, old and out-of-range requests through the
// receiver under random source gaps and sink stalls. A scoreboard predicts
// every delivery and ack and checks them in order against the result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import srr_pkg::*;

    localparam int PAYLOAD_BYTES = 20;
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_ITEMS  = 300;
    localparam int PHASE_ITEMS   = 100;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 200000;

    // One request as it sits on the input channel
    typedef struct {
        int              seq;
        int              ackf;
        int              cks;
        logic [LO_W-1:0]  lo;
        logic [MID_W-1:0] mid;
        logic [HI_W-1:0]  hi;
    } request_t;

    // One item on the result channel
    typedef struct {
        logic                kind;
        logic                ack_seq;
        logic [ACKNUM_W-1:0] ack_number;
        logic [ACKSUM_W-1:0] ack_sum;
        logic [LO_W-1:0]     data_lo;
        logic [MID_W-1:0]    data_mid;
        logic [HI_W-1:0]     data_hi;
        logic                last;
    } result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the receive window, predicts the
    // deliveries and the closing ack of every accepted request, and checks
    // results in arrival order.
    // ------------------------------------------------------------------------
    class receiver_scoreboard;
        logic [LO_W-1:0]  slot_lo  [SEQ_SPACE];
        logic [MID_W-1:0] slot_mid [SEQ_SPACE];
        logic [HI_W-1:0]  slot_hi  [SEQ_SPACE];
        bit               slot_full[SEQ_SPACE];
        int               rx_base;
        bit               ack_toggle;
        result_t          pending_results[$];

        int failures;
        int delivered;
        int acks_sent;
        int corrupted;
        int ignored;
        int longest_run;

        function new();
            foreach (slot_full[i]) slot_full[i] = 1'b0;
            rx_base    = 0;
            ack_toggle = 1'b1;
        endfunction

        // Sum of all payload bytes, each read as a signed byte, modulo 2^32
        static function bit [31:0] payload_sum(logic [LO_W-1:0] lo,
                                               logic [MID_W-1:0] mid,
                                               logic [HI_W-1:0] hi);
            logic [8*PAYLOAD_BYTES-1:0] all_bytes;
            bit [31:0]                  acc;
            all_bytes = {hi, mid, lo};
            acc = '0;
            for (int i = 0; i < PAYLOAD_BYTES; i++)
                acc += {{24{all_bytes[8*i+7]}}, all_bytes[8*i +: 8]};
            return acc;
        endfunction

        function void push_ack(bit seqbit, int num);
            result_t r;
            r.kind       = KIND_ACK;
            r.ack_seq    = seqbit;
            r.ack_number = ACKNUM_W'(num);
            r.ack_sum    = ACKSUM_W'(int'(seqbit) + num + ACK_FILL_SUM);
            r.data_lo    = '0;
            r.data_mid   = '0;
            r.data_hi    = '0;
            r.last       = 1'b1;
            pending_results.push_back(r);
            acks_sent++;
        endfunction

        // Predict the results of one accepted request; returns their count
        function int note_request(request_t p);
            bit        seqbit;
            bit [31:0] sum;
            int        d;
            int        run;
            result_t   r;
            seqbit     = ack_toggle;
            ack_toggle = ~ack_toggle;
            sum = 32'(p.seq) + 32'(p.ackf) + payload_sum(p.lo, p.mid, p.hi);
            if (sum != 32'(p.cks)) begin
                corrupted++;
                push_ack(seqbit, (rx_base + SEQ_SPACE - 1) % SEQ_SPACE);
                return 1;
            end
            if (p.seq < 0 || p.seq >= SEQ_SPACE) begin
                ignored++;
                return 0;
            end
            d = (p.seq + SEQ_SPACE - rx_base) % SEQ_SPACE;
            if (d < RECV_WINDOW) begin
                // Keep the first copy of a duplicate
                if (!slot_full[p.seq]) begin
                    slot_lo[p.seq]   = p.lo;
                    slot_mid[p.seq]  = p.mid;
                    slot_hi[p.seq]   = p.hi;
                    slot_full[p.seq] = 1'b1;
                end
                run = 0;
                while (run < DELIV_MAX && slot_full[rx_base]) begin
                    r.kind       = KIND_DELIVER;
                    r.ack_seq    = 1'b0;
                    r.ack_number = '0;
                    r.ack_sum    = '0;
                    r.data_lo    = slot_lo[rx_base];
                    r.data_mid   = slot_mid[rx_base];
                    r.data_hi    = slot_hi[rx_base];
                    r.last       = 1'b0;
                    pending_results.push_back(r);
                    slot_full[rx_base] = 1'b0;
                    rx_base = (rx_base + 1) % SEQ_SPACE;
                    run++;
                end
                delivered += run;
                if (run > longest_run) longest_run = run;
                push_ack(seqbit, p.seq);
                return run + 1;
            end
            if (d >= SEQ_SPACE - RECV_WINDOW) begin
                push_ack(seqbit, p.seq);
                return 1;
            end
            ignored++;
            return 0;
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: kind %0b ack_number %0d",
                       got.kind, got.ack_number);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            compare("kind",       want.kind,       got.kind);
            compare("ack_seq",    want.ack_seq,    got.ack_seq);
            compare("ack_number", want.ack_number, got.ack_number);
            compare("ack_sum",    want.ack_sum,    got.ack_sum);
            compare("data_lo",    want.data_lo,    got.data_lo);
            compare("data_mid",   want.data_mid,   got.data_mid);
            compare("data_hi",    want.data_hi,    got.data_hi);
            compare("last",       want.last,       got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn;

    logic                s_valid;
    logic                s_ready;
    logic signed [31:0]  s_seq_num;
    logic signed [31:0]  s_ack_field;
    logic signed [31:0]  s_pkt_checksum;
    logic [LO_W-1:0]     s_payload_lo;
    logic [MID_W-1:0]    s_payload_mid;
    logic [HI_W-1:0]     s_payload_hi;

    logic                m_valid;
    logic                m_ready;
    logic                m_kind;
    logic                m_ack_seq;
    logic [ACKNUM_W-1:0] m_ack_number;
    logic [ACKSUM_W-1:0] m_ack_sum;
    logic [LO_W-1:0]     m_data_lo;
    logic [MID_W-1:0]    m_data_mid;
    logic [HI_W-1:0]     m_data_hi;
    logic                m_last;

    always #CLK_HALF aclk = ~aclk;

    selective_repeat_receiver dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_seq_num      (s_seq_num),
        .s_ack_field    (s_ack_field),
        .s_pkt_checksum (s_pkt_checksum),
        .s_payload_lo   (s_payload_lo),
        .s_payload_mid  (s_payload_mid),
        .s_payload_hi   (s_payload_hi),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_ack_seq      (m_ack_seq),
        .m_ack_number   (m_ack_number),
        .m_ack_sum      (m_ack_sum),
        .m_data_lo      (m_data_lo),
        .m_data_mid     (m_data_mid),
        .m_data_hi      (m_data_hi),
        .m_last         (m_last)
    );

    receiver_scoreboard sb;
    int                 source_gap_pct;
    int                 sink_stall_pct;
    int                 cycles;
    int                 requests;

    // ------------------------------------------------------------------------
    // Watchdog: end the run if the results never drain
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sink: stall at random, change ready only on the falling edge
    always @(negedge aclk) begin
        if (aresetn)
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Monitor: check every result accepted at a rising edge
    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            got.kind       = m_kind;
            got.ack_seq    = m_ack_seq;
            got.ack_number = m_ack_number;
            got.ack_sum    = m_ack_sum;
            got.data_lo    = m_data_lo;
            got.data_mid   = m_data_mid;
            got.data_hi    = m_data_hi;
            got.last       = m_last;
            sb.check_result(got);
        end
    end

    // Build a request whose checksum matches its contents
    function automatic request_t build_request(int seq, logic [LO_W-1:0] lo,
                                               logic [MID_W-1:0] mid,
                                               logic [HI_W-1:0] hi, int ackf);
        request_t p;
        p.seq  = seq;
        p.ackf = ackf;
        p.lo   = lo;
        p.mid  = mid;
        p.hi   = hi;
        p.cks  = int'(32'(seq) + 32'(ackf) + receiver_scoreboard::payload_sum(lo, mid, hi));
        return p;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Present one request, hold it until accepted, then predict its results.
    // The source may first idle at random.
    task automatic send_request(input request_t p, output int produced);
        @(negedge aclk);
        while ($urandom_range(0, 99) < source_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_seq_num      <= p.seq;
        s_ack_field    <= p.ackf;
        s_pkt_checksum <= p.cks;
        s_payload_lo   <= p.lo;
        s_payload_mid  <= p.mid;
        s_payload_hi   <= p.hi;
        do @(posedge aclk); while (s_ready !== 1'b1);
        produced = sb.note_request(p);
        requests++;
    endtask

    // Pick a random request, mostly well-formed traffic around the window
    function automatic request_t random_request();
        request_t p;
        int       pick;
        int       seq;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            // In-window request with random content
            seq = (sb.rx_base + $urandom_range(0, RECV_WINDOW - 1)) % SEQ_SPACE;
            p = build_request(seq, rand64(), rand64(), $urandom, $urandom);
        end else if (pick < 68) begin
            // Old request just before the window
            seq = (sb.rx_base + SEQ_SPACE - 1) % SEQ_SPACE;
            p = build_request(seq, rand64(), rand64(), $urandom, $urandom);
        end else if (pick < 82) begin
            // Flip one checksum bit
            seq = $urandom_range(0, SEQ_SPACE - 1);
            p = build_request(seq, rand64(), rand64(), $urandom, $urandom);
            p.cks = p.cks ^ int'(32'd1 << $urandom_range(0, 31));
        end else if (pick < 92) begin
            // Good checksum, sequence number outside the sequence space
            seq = $urandom;
            if (seq >= 0 && seq < SEQ_SPACE) seq = -seq - 1;
            p = build_request(seq, rand64(), rand64(), $urandom, $urandom);
        end else begin
            // Pure noise
            p.seq  = $urandom;
            p.ackf = $urandom;
            p.cks  = $urandom;
            p.lo   = rand64();
            p.mid  = rand64();
            p.hi   = $urandom;
        end
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        request_t p;
        int       produced;
        int       counted;

        sb             = new();
        cycles         = 0;
        requests       = 0;
        source_gap_pct = 20;
        sink_stall_pct = 55;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_seq_num      = '0;
        s_ack_field    = '0;
        s_pkt_checksum = '0;
        s_payload_lo   = '0;
        s_payload_mid  = '0;
        s_payload_hi   = '0;
        m_ready        = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- Directed part: the window starts at zero ---
        // In order with all-ones bytes and the most negative ack field
        send_request(build_request(0, '1, '1, '1, 32'h8000_0000), produced);
        // Old request: re-ack only
        send_request(build_request(0, '0, '0, '0, 32'h7fff_ffff), produced);
        // Corrupted request with the most negative checksum
        p = build_request(1, '0, '0, '0, 0);
        p.cks = 32'h8000_0000;
        send_request(p, produced);
        // Fill the rest of the window out of order, leaving a hole at one
        send_request(build_request(2, {8{8'h80}}, {8{8'h80}}, {4{8'h80}}, 5), produced);
        send_request(build_request(3, {8{8'h7f}}, {8{8'h7f}}, {4{8'h7f}}, -5), produced);
        send_request(build_request(4, rand64(), rand64(), $urandom, $urandom), produced);
        send_request(build_request(5, rand64(), rand64(), $urandom, $urandom), produced);
        send_request(build_request(6, rand64(), rand64(), $urandom, $urandom), produced);
        // Duplicate with new content: the first copy must be kept
        send_request(build_request(3, rand64(), rand64(), $urandom, $urandom), produced);
        // Close the hole: six payloads release in one go
        send_request(build_request(1, rand64(), rand64(), $urandom, $urandom), produced);
        // Sequence numbers outside the sequence space: dropped silently
        send_request(build_request(-1, rand64(), rand64(), $urandom, $urandom), produced);
        send_request(build_request(SEQ_SPACE, rand64(), rand64(), $urandom, 0), produced);
        send_request(build_request(32'h8000_0000, '1, '0, '1, $urandom), produced);
        send_request(build_request(32'h7fff_ffff, '0, '1, '0, $urandom), produced);
        // Checksum at both extremes on good requests
        p = build_request(0, rand64(), rand64(), $urandom, 0);
        p.ackf = int'(32'h7fff_ffff - 32'(p.seq)
                      - receiver_scoreboard::payload_sum(p.lo, p.mid, p.hi));
        p.cks  = 32'h7fff_ffff;
        send_request(p, produced);
        p = build_request(1, rand64(), rand64(), $urandom, 0);
        p.ackf = int'(32'h8000_0000 - 32'(p.seq)
                      - receiver_scoreboard::payload_sum(p.lo, p.mid, p.hi));
        p.cks  = 32'h8000_0000;
        send_request(p, produced);
        // In-window request past a hole, then a corrupted request in that state
        send_request(build_request(6, rand64(), rand64(), $urandom, 0), produced);
        p = build_request(4, rand64(), rand64(), $urandom, $urandom);
        p.cks = ~p.cks;
        send_request(p, produced);

        // --- Random part: three idling phases ---
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted == PHASE_ITEMS) begin
                source_gap_pct = 55;
                sink_stall_pct = 20;
            end else if (counted == 2 * PHASE_ITEMS) begin
                source_gap_pct = 0;
                sink_stall_pct = 0;
            end
            send_request(random_request(), produced);
            counted++;
        end

        // Drop valid and let the results drain
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests: %0d corrupted, %0d dropped as out of range.",
                 requests, sb.corrupted, sb.ignored);
        $display("Released %0d payloads (longest in-order run %0d), sent %0d acks.",
                 sb.delivered, sb.longest_run, sb.acks_sent);
        if (sb.failures == 0 && sb.pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### selective_repeat_receiver.f
+incdir+hw/rtl
hw/rtl/srr_pkg.sv
hw/rtl/srr_slot_ram.sv
hw/rtl/selective_repeat_receiver.sv
dv/testbench.sv
